/* rtl/sht_pkg.sv */
// Shared types and codes for the slot handle table.
// Holds field widths, action and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package sht_pkg;

    localparam int ACT_W = 3;
    localparam int IDX_W = 8;
    localparam int VAL_W = 64;
    localparam int STS_W = 2;
    localparam int CNT_W = 9;

    // Request actions; codes 6 and 7 carry no meaning.
    localparam logic [ACT_W-1:0] ACT_INS_FREE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_AT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REM_AT   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REM_VAL  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIND     = 3'd5;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd2;
    localparam logic [STS_W-1:0] STS_MISS  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_FREE_SCAN,
        ST_VAL_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;       // capture the request
        logic dispatch;   // decide direct actions, start scans
        logic read_done;  // take slot data from memory
        logic free_step;  // test one occupancy flag
        logic val_step;   // issue one address, compare one entry
        logic commit;     // apply update and load the result register
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             in_range;
        logic             occ_idx;
        logic             free_found;
        logic             scan_last;
        logic             val_hit;
        logic             val_last;
        logic             out_free;
    } t_sts;

endpackage

/* rtl/sht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/sht_ctrl.sv */
// Controller state machine of the slot handle table.
// Depends on sht_pkg for states and the command/status structs.
module sht_ctrl
    import sht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_sts.action)
                    ACT_INS_FREE: n_state = ST_FREE_SCAN;
                    ACT_REM_VAL,
                    ACT_FIND:     n_state = ST_VAL_SCAN;
                    ACT_READ: begin
                        n_state = (i_sts.in_range && i_sts.occ_idx) ? ST_READ : ST_FINISH;
                    end
                    default:      n_state = ST_FINISH;
                endcase
            end
            ST_READ: n_state = ST_FINISH;
            ST_FREE_SCAN: begin
                if (i_sts.free_found || i_sts.scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_VAL_SCAN: begin
                if (i_sts.val_hit || i_sts.val_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        o_cmd           = '0;
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.dispatch  = (r_state == ST_DISPATCH);
        o_cmd.read_done = (r_state == ST_READ);
        o_cmd.free_step = (r_state == ST_FREE_SCAN);
        o_cmd.val_step  = (r_state == ST_VAL_SCAN);
        o_cmd.commit    = (r_state == ST_FINISH) && i_sts.out_free;
    end

endmodule

/* rtl/sht_dp.sv */
// Datapath of the slot handle table: request registers, occupancy flags,
// live count, scan counter, handle memory and result register.
// Depends on sht_pkg and sht_ram.
module sht_dp
    import sht_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [ACT_W-1:0] i_action,
    input  logic [IDX_W-1:0] i_slot_index,
    input  logic [VAL_W-1:0] i_item_value,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [STS_W-1:0] o_status,
    output logic [IDX_W-1:0] o_result_slot,
    output logic [VAL_W-1:0] o_result_value,
    output logic [CNT_W-1:0] o_live_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0]  LAST_SLOT = IW'(SLOTS - 1);
    localparam logic [IDX_W:0] SLOTS_X   = (IDX_W + 1)'(SLOTS);

    // Request
    logic [ACT_W-1:0] r_action;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;

    // Table state
    logic [SLOTS-1:0] r_occ;
    logic [CW-1:0]    r_live;
    logic [CW-1:0]    n_live;

    // Scan
    logic [IW-1:0] r_scan;
    logic          r_issue_done;
    logic          r_chk_vld;
    logic [IW-1:0] r_chk_idx;

    // Pending result and update
    logic [STS_W-1:0] r_res_status;
    logic [IDX_W-1:0] r_res_slot;
    logic [VAL_W-1:0] r_res_value;
    logic             r_upd_set;
    logic             r_upd_clr;
    logic             r_upd_wr;
    logic [IW-1:0]    r_upd_slot;

    // Output register
    logic             r_out_valid;
    logic [STS_W-1:0] r_out_status;
    logic [IDX_W-1:0] r_out_slot;
    logic [VAL_W-1:0] r_out_value;
    logic [CW-1:0]    r_out_live;

    logic [IW-1:0]    idx_lo;
    logic             in_range;
    logic             occ_idx;
    logic [STS_W-1:0] idx_status;
    logic             val_hit;
    logic             val_last;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic [VAL_W-1:0] rd_data;

    assign idx_lo     = r_idx[IW-1:0];
    assign in_range   = ({1'b0, r_idx} < SLOTS_X);
    assign occ_idx    = in_range && r_occ[idx_lo];
    assign idx_status = !in_range ? STS_RANGE : (!occ_idx ? STS_MISS : STS_OK);
    assign val_hit    = r_chk_vld && r_occ[r_chk_idx] && (rd_data == r_val);
    assign val_last   = r_chk_vld && (r_chk_idx == LAST_SLOT);
    assign rd_en      = i_cmd.dispatch || i_cmd.val_step;
    assign rd_addr    = i_cmd.val_step ? r_scan : idx_lo;

    always_comb begin
        o_sts            = '0;
        o_sts.action     = r_action;
        o_sts.in_range   = in_range;
        o_sts.occ_idx    = occ_idx;
        o_sts.free_found = !r_occ[r_scan];
        o_sts.scan_last  = (r_scan == LAST_SLOT);
        o_sts.val_hit    = val_hit;
        o_sts.val_last   = val_last;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_live = r_live;
        if (r_upd_set) begin
            n_live = r_live + 1'b1;
        end else if (r_upd_clr) begin
            n_live = r_live - 1'b1;
        end
    end

    sht_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && r_upd_wr),
        .i_wr_addr (r_upd_slot),
        .i_wr_data (r_val),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Request capture, decisions and scans
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_idx    <= i_slot_index;
            r_val    <= i_item_value;
        end

        if (i_cmd.dispatch) begin
            r_res_value  <= '0;
            r_upd_slot   <= idx_lo;
            r_scan       <= '0;
            r_issue_done <= 1'b0;
            r_chk_vld    <= 1'b0;
            unique case (r_action)
                ACT_INS_AT: begin
                    r_res_slot   <= r_idx;
                    r_res_status <= in_range ? STS_OK : STS_RANGE;
                    r_upd_wr     <= in_range;
                    r_upd_set    <= in_range && !occ_idx;
                    r_upd_clr    <= 1'b0;
                end
                ACT_REM_AT: begin
                    r_res_slot   <= r_idx;
                    r_res_status <= idx_status;
                    r_upd_wr     <= 1'b0;
                    r_upd_set    <= 1'b0;
                    r_upd_clr    <= occ_idx;
                end
                ACT_READ: begin
                    r_res_slot   <= r_idx;
                    r_res_status <= idx_status;
                    r_upd_wr     <= 1'b0;
                    r_upd_set    <= 1'b0;
                    r_upd_clr    <= 1'b0;
                end
                default: begin
                    // scans start here; meaningless actions answer ok
                    r_res_slot   <= '0;
                    r_res_status <= STS_OK;
                    r_upd_wr     <= 1'b0;
                    r_upd_set    <= 1'b0;
                    r_upd_clr    <= 1'b0;
                end
            endcase
        end

        if (i_cmd.read_done) begin
            r_res_value <= rd_data;
        end

        if (i_cmd.free_step) begin
            if (!r_occ[r_scan]) begin
                r_res_slot <= IDX_W'(r_scan);
                r_upd_slot <= r_scan;
                r_upd_set  <= 1'b1;
                r_upd_wr   <= 1'b1;
            end else if (r_scan == LAST_SLOT) begin
                r_res_status <= STS_FULL;
            end else begin
                r_scan <= r_scan + 1'b1;
            end
        end

        if (i_cmd.val_step) begin
            // issue side: one address a cycle up to the last slot
            if (!r_issue_done) begin
                r_chk_vld <= 1'b1;
                r_chk_idx <= r_scan;
                if (r_scan == LAST_SLOT) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_scan <= r_scan + 1'b1;
                end
            end else begin
                r_chk_vld <= 1'b0;
            end
            // compare side: data of the previous address
            if (val_hit) begin
                r_res_slot <= IDX_W'(r_chk_idx);
                r_upd_slot <= r_chk_idx;
                r_upd_clr  <= (r_action == ACT_REM_VAL);
            end else if (val_last) begin
                r_res_status <= STS_MISS;
            end
        end

        if (i_cmd.commit) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_value  <= r_res_value;
            r_out_live   <= n_live;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_live <= n_live;
                if (r_upd_set) begin
                    r_occ[r_upd_slot] <= 1'b1;
                end else if (r_upd_clr) begin
                    r_occ[r_upd_slot] <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_result_slot  = r_out_slot;
    assign o_result_value = r_out_value;
    assign o_live_count   = CNT_W'(r_out_live);

endmodule

/* rtl/slot_handle_table_core.sv */
// Slot handle table: fixed table of SLOTS 64-bit handles with occupancy flags.
// Usage:
//   Input channel  i_in_valid / o_in_ready carries one request item: action,
//   slot index and handle value. Output channel o_out_valid / i_out_ready
//   carries one result item per request: status, slot, value, live count.
//   Path from acceptance to result valid:
//     insert at / remove at / unused actions : dispatch, finish
//     read : dispatch, memory read if in range and occupied, finish
//     insert first free : dispatch, flag tests up to a free or the last slot
//     remove by value / find : dispatch, then a memory walk that reads
//       one stored handle per cycle and compares it in the next cycle;
//       it stops early on the first match.
//   One request is in flight at a time; o_in_ready rises in the cycle after
//   the result is loaded.
//   Reset clears all occupancy flags, the live count and the output valid.
//   The handle memory is not cleared; slot data is only used when occupied.
//   A stalled receiver holds the result in the output register; a finished
//   request waits in the finish state until the register frees, and the
//   next request may be accepted while the previous result still waits.
// Depends on sht_pkg, sht_ctrl, sht_dp and sht_ram.
module slot_handle_table_core
    import sht_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ACT_W-1:0] i_action,
    input  logic [IDX_W-1:0] i_slot_index,
    input  logic [VAL_W-1:0] i_item_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [STS_W-1:0] o_status,
    output logic [IDX_W-1:0] o_result_slot,
    output logic [VAL_W-1:0] o_result_value,
    output logic [CNT_W-1:0] o_live_count
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each request through dispatch, scan or read, and commit.
    sht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the table, walk it and drive the result register.
    sht_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_slot_index   (i_slot_index),
        .i_item_value   (i_item_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_result_slot  (o_result_slot),
        .o_result_value (o_result_value),
        .o_live_count   (o_live_count)
    );

endmodule

/* rtl/sht_checker.sv */
// Port-level checks for the slot handle table, bound to the top level.
// Depends on sht_pkg and slot_handle_table_core.
module sht_checker
    import sht_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [STS_W-1:0] o_status,
    input logic [IDX_W-1:0] o_result_slot,
    input logic [VAL_W-1:0] o_result_value,
    input logic [CNT_W-1:0] o_live_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_result_slot) && $stable(o_live_count))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_FULL) |-> (o_live_count == SLOTS))
        else $error("table full with free slots");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_value != '0) |-> (o_status == STS_OK))
        else $error("value returned on failed request");

    a_range_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_RANGE) |-> (o_result_slot >= SLOTS))
        else $error("range status on a slot inside the table");

endmodule

bind slot_handle_table_core sht_checker #(.SLOTS(SLOTS)) u_sht_checker (.*);
